### rtl/tkr_pkg.sv
// Shared types, constants and ranking helpers for the top-K result ranker.
package tkr_pkg;

   localparam int CAPACITY_DEFAULT = 64;
   localparam int COORD_W = 32;
   localparam int COUNT_W = 16;
   localparam int KEEP_W = 7;
   localparam int ENTRY_W = 2 * COORD_W + COUNT_W;
   localparam int DIST_W = 2 * COORD_W + 1;
   localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

   // Input command codes.
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   // Command from controller to datapath.
   typedef struct packed {
      logic load_new;    // capture the request item and its distance
      logic rd_start;    // issue a read at the address given
      logic shift_wr;    // write the held entry one slot down
      logic place_wr;    // write the new entry at the address given
      logic drain_load;  // capture read data into the result register
      logic empty_load;  // load the empty-drain result
   } ctrl_cmd_type;

   // Status from datapath to controller.
   typedef struct packed {
      logic new_better;  // new entry ranks strictly above the entry just read
   } dp_stat_type;

   // Absolute value of a 32-bit two's complement number as 32-bit unsigned.
   function automatic logic [COORD_W-1:0] abs32(input logic [COORD_W-1:0] v);
      abs32 = v[COORD_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage

### rtl/tkr_ram.sv
// Generic single-port write, single-port registered read RAM.
module tkr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end
endmodule

### rtl/tkr_datapath.sv
// Datapath: entry store, distance unit, rank compare and result register.
module tkr_datapath #(
   parameter int CAPACITY = tkr_pkg::CAPACITY_DEFAULT,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
   input  logic                                clock,
   input  tkr_pkg::ctrl_cmd_type               cmd,
   input  logic [AW-1:0]                       addr,
   input  logic                                last,
   input  logic signed [tkr_pkg::COORD_W-1:0]  req_coord_x,
   input  logic signed [tkr_pkg::COORD_W-1:0]  req_coord_z,
   input  logic [tkr_pkg::COUNT_W-1:0]         req_cell_count,
   output tkr_pkg::dp_stat_type                stat,
   output logic signed [tkr_pkg::COORD_W-1:0]  rsp_out_x,
   output logic signed [tkr_pkg::COORD_W-1:0]  rsp_out_z,
   output logic [tkr_pkg::COUNT_W-1:0]         rsp_out_count,
   output logic                                rsp_is_last,
   output logic                                rsp_is_empty
);
   localparam int CW = tkr_pkg::COORD_W;
   localparam int NW = tkr_pkg::COUNT_W;
   localparam int EW = tkr_pkg::ENTRY_W;
   localparam int DW = tkr_pkg::DIST_W;
   localparam int RAM_DEPTH = (CAPACITY > 1) ? CAPACITY : 2;

   logic [CW-1:0] new_x_ff, new_z_ff;
   logic [NW-1:0] new_c_ff;
   logic [DW-1:0] new_d_ff;
   logic [2*CW-1:0] sq_x_in, sq_z_in;
   logic [EW-1:0] rd_data;
   logic [CW-1:0] rd_x, rd_z;
   logic [NW-1:0] rd_c;
   logic [2*CW-1:0] rsq_x_ff, rsq_z_ff;
   logic [CW-1:0] old_x_ff, old_z_ff;
   logic [NW-1:0] old_c_ff;
   logic [DW-1:0] old_d;
   logic [EW-1:0] wr_data;
   logic [AW-1:0] wr_addr;

   assign {rd_x, rd_z, rd_c} = rd_data;

   // Squares of the request coordinates.
   assign sq_x_in = (2*CW)'(tkr_pkg::abs32(req_coord_x)) * (2*CW)'(tkr_pkg::abs32(req_coord_x));
   assign sq_z_in = (2*CW)'(tkr_pkg::abs32(req_coord_z)) * (2*CW)'(tkr_pkg::abs32(req_coord_z));

   // New entry and its distance; squares of read entry registered separately.
   always_ff @(posedge clock) begin
      if (cmd.load_new) begin
         new_x_ff <= req_coord_x;
         new_z_ff <= req_coord_z;
         new_c_ff <= req_cell_count;
         new_d_ff <= {1'b0, sq_x_in} + {1'b0, sq_z_in};
      end
      rsq_x_ff <= (2*CW)'(tkr_pkg::abs32(rd_x)) * (2*CW)'(tkr_pkg::abs32(rd_x));
      rsq_z_ff <= (2*CW)'(tkr_pkg::abs32(rd_z)) * (2*CW)'(tkr_pkg::abs32(rd_z));
      old_x_ff <= rd_x;
      old_z_ff <= rd_z;
      old_c_ff <= rd_c;
   end

   assign old_d = {1'b0, rsq_x_ff} + {1'b0, rsq_z_ff};

   // Rank compare of the new entry against the stored entry just squared.
   always_comb begin
      if (new_c_ff != old_c_ff) begin
         stat.new_better = new_c_ff > old_c_ff;
      end else if (new_d_ff != old_d) begin
         stat.new_better = new_d_ff < old_d;
      end else if (new_x_ff != old_x_ff) begin
         stat.new_better = $signed(new_x_ff) < $signed(old_x_ff);
      end else begin
         stat.new_better = $signed(new_z_ff) < $signed(old_z_ff);
      end
   end

   // Shift writes move the compared entry down one slot.
   always_comb begin
      if (cmd.shift_wr) begin
         wr_data = {old_x_ff, old_z_ff, old_c_ff};
         wr_addr = addr;
      end else begin
         wr_data = {new_x_ff, new_z_ff, new_c_ff};
         wr_addr = addr;
      end
   end

   tkr_ram #(.WIDTH(EW), .DEPTH(RAM_DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (cmd.shift_wr | cmd.place_wr),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (cmd.rd_start),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (cmd.empty_load) begin
         rsp_out_x <= '0;
         rsp_out_z <= '0;
         rsp_out_count <= '0;
         rsp_is_last <= 1'b1;
         rsp_is_empty <= 1'b1;
      end else if (cmd.drain_load) begin
         rsp_out_x <= rd_x;
         rsp_out_z <= rd_z;
         rsp_out_count <= rd_c;
         rsp_is_last <= last;
         rsp_is_empty <= 1'b0;
      end
   end
endmodule

### rtl/tkr_control.sv
// Controller: sequences insertion sort steps and drains over the store.
module tkr_control #(
   parameter int CAPACITY = tkr_pkg::CAPACITY_DEFAULT,
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
   localparam int OW = $clog2(CAPACITY + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic                        req_command,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [tkr_pkg::KEEP_W-1:0]  keep,
   input  tkr_pkg::dp_stat_type        stat,
   output tkr_pkg::ctrl_cmd_type       cmd,
   output logic [AW-1:0]               addr,
   output logic                        last,
   output logic [OW-1:0]               occ_out
);
   typedef enum logic [2:0] {
      S_IDLE, S_RD, S_SQ, S_CMP, S_DRD, S_DOUT
   } state_type;

   state_type state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [OW:0] eff_k;
   logic accept, full;

   // Effective K: zero acts as one, large values clamp to capacity.
   always_comb begin
      if (keep == '0) begin
         eff_k = (OW+1)'(1);
      end else if (int'(keep) > CAPACITY) begin
         eff_k = (OW+1)'(CAPACITY);
      end else begin
         eff_k = (OW+1)'(keep);
      end
   end

   assign full = ({1'b0, occ_ff} >= eff_k);
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign occ_out = occ_ff;

   // Next-state and command decode.
   always_comb begin
      state_in = state_ff;
      occ_in = occ_ff;
      pos_in = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      addr = AW'(pos_ff - 1'b1);
      last = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.load_new = 1'b1;
               if (req_command == tkr_pkg::CMD_DRAIN) begin
                  if (occ_ff == '0) begin
                     cmd.empty_load = 1'b1;
                     rsp_valid_in = 1'b1;
                  end else begin
                     pos_in = '0;
                     state_in = S_DRD;
                  end
               end else if (!full) begin
                  pos_in = occ_ff;
                  occ_in = occ_ff + 1'b1;
                  state_in = (occ_ff == '0) ? S_CMP : S_RD;
               end else begin
                  // Full: new entry must beat the worst, which it replaces.
                  pos_in = occ_ff;
                  state_in = S_RD;
               end
            end
         end
         S_RD: begin
            cmd.rd_start = 1'b1;
            state_in = S_SQ;
         end
         S_SQ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (pos_ff != '0 && stat.new_better) begin
               // Move the compared entry down, unless it is the dropped worst.
               if (pos_ff != occ_ff) begin
                  cmd.shift_wr = 1'b1;
                  addr = AW'(pos_ff);
               end
               pos_in = pos_ff - 1'b1;
               state_in = (pos_ff == OW'(1)) ? S_CMP : S_RD;
               if (pos_ff != OW'(1)) begin
                  cmd.rd_start = 1'b1;
                  addr = AW'(pos_ff - 2'd2);
                  if (pos_ff != occ_ff) begin
                     addr = AW'(pos_ff);
                     cmd.rd_start = 1'b0;
                  end
               end
            end else begin
               // Place the new entry, unless it lost to the worst of a full store.
               if (pos_ff == '0 || pos_ff != occ_ff) begin
                  cmd.place_wr = 1'b1;
                  addr = AW'(pos_ff);
               end
               state_in = S_IDLE;
            end
         end
         S_DRD: begin
            cmd.rd_start = 1'b1;
            addr = AW'(pos_ff);
            state_in = S_DOUT;
         end
         S_DOUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.drain_load = 1'b1;
               last = (pos_ff + 1'b1 == occ_ff);
               addr = AW'(pos_ff);
               rsp_valid_in = 1'b1;
               if (pos_ff + 1'b1 == occ_ff) begin
                  occ_in = '0;
                  state_in = S_IDLE;
               end else begin
                  pos_in = pos_ff + 1'b1;
                  state_in = S_DRD;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and registered outputs.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         occ_ff <= '0;
         pos_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         occ_ff <= occ_in;
         pos_ff <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

### rtl/top_k_result_ranker.sv
// Top-K result ranker: controller, datapath and keep-count register.
// Insert: into an empty store the entry is placed directly; else each stored entry
// compared takes a read, a square and a compare step before the entry is placed.
// Drain: each item is read from the store, then output, and output stalls hold the
// drain; an empty drain gives its one item, marked empty and last.
// One item in flight. Synchronous active-high reset empties the store and sets K to 64.
module top_k_result_ranker #(
   parameter int CAPACITY = tkr_pkg::CAPACITY_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_command,
   input  logic signed [tkr_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [tkr_pkg::COORD_W-1:0] req_coord_z,
   input  logic [tkr_pkg::COUNT_W-1:0]        req_cell_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [tkr_pkg::COORD_W-1:0] rsp_out_x,
   output logic signed [tkr_pkg::COORD_W-1:0] rsp_out_z,
   output logic [tkr_pkg::COUNT_W-1:0]        rsp_out_count,
   output logic                               rsp_is_last,
   output logic                               rsp_is_empty,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tkr_pkg::KEEP_W-1:0]         csr_keep_count
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int OW = $clog2(CAPACITY + 1);

   logic [tkr_pkg::KEEP_W-1:0] keep_ff;
   tkr_pkg::ctrl_cmd_type cmd;
   tkr_pkg::dp_stat_type stat;
   logic [AW-1:0] addr;
   logic last;
   logic [OW-1:0] occ;

   // Keep-count register.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         keep_ff <= tkr_pkg::KEEP_RESET;
      end else if (csr_valid && csr_ready) begin
         keep_ff <= csr_keep_count;
      end
   end

   tkr_control #(.CAPACITY(CAPACITY)) u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .keep(keep_ff), .stat(stat), .cmd(cmd), .addr(addr), .last(last),
      .occ_out(occ)
   );

   tkr_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock(clock), .cmd(cmd), .addr(addr), .last(last),
      .req_coord_x(req_coord_x), .req_coord_z(req_coord_z),
      .req_cell_count(req_cell_count), .stat(stat),
      .rsp_out_x(rsp_out_x), .rsp_out_z(rsp_out_z), .rsp_out_count(rsp_out_count),
      .rsp_is_last(rsp_is_last), .rsp_is_empty(rsp_is_empty)
   );

`ifndef SYNTHESIS
   // Occupancy never exceeds capacity.
   a_occ_cap: assert property (@(posedge clock) disable iff (reset)
      occ <= OW'(CAPACITY)) else $error("occupancy above capacity");
   // No input is taken while a result waits.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("input accepted with result pending");
   // An empty result is always the last of its drain.
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_empty) |-> rsp_is_last) else $error("empty not last");
`endif
endmodule
